// ----- src/tzc_pkg.sv -----
package tzc_pkg;

  localparam int unsigned STAMP_W    = 16;
  localparam int unsigned MID_W      = 17;
  localparam int unsigned PERIOD_W   = 32;
  localparam int unsigned POWER_W    = 14;
  localparam int unsigned DELAY_W    = 14;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;

  localparam int unsigned FEED_WINDOW = 500;
  localparam int unsigned CNT_W       = $clog2(FEED_WINDOW + 1);
  localparam int unsigned DUTY_MAX    = 100;

  localparam logic [STAMP_W-1:0]  WRAP           = 16'hffff;
  localparam logic [POWER_W-1:0]  POWER_DEFAULT  = POWER_W'(60);
  localparam logic [PERIOD_W-1:0] T7_ZERO_SUB    = PERIOD_W'(220);
  localparam logic [DELAY_W-1:0]  MAX_DELAY      = DELAY_W'(8999);
  localparam logic [DELAY_W-1:0]  GOOD_DELAY_RST = DELAY_W'(4500);

  localparam int unsigned OUT_FIELD_W = DELAY_W + STAMP_W + 3;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef cnt_t on_tbl_t [DUTY_MAX+1];

  typedef enum logic {
    EDGE_FALL = 1'b0,
    EDGE_RISE = 1'b1
  } edge_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOKE_POWER     = 3'd0,
    REG_SMOKE_ENABLE    = 3'd1,
    REG_EXCHANGE_ENABLE = 3'd2,
    REG_FEED_MANUAL     = 3'd3,
    REG_FEED_ALWAYS     = 3'd4,
    REG_FEED_AUTO       = 3'd5,
    REG_FEED_SHARE      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [POWER_W-1:0] smoke_power;
    logic               smoke_enable;
    logic               exchange_enable;
    logic               feed_manual;
    logic               feed_always;
    logic               feed_auto;
    logic [DUTY_W-1:0]  feed_share;
  } cfg_t;

  function automatic on_tbl_t build_on_tbl();
    on_tbl_t tbl;
    for (int i = 0; i <= int'(DUTY_MAX); i++) begin
      tbl[i] = cnt_t'((i * int'(FEED_WINDOW)) / 100);
    end
    return tbl;
  endfunction

  localparam on_tbl_t ON_TBL    = build_on_tbl();
  localparam cnt_t    HALF_CNT  = cnt_t'(FEED_WINDOW / 2);
  localparam cnt_t    WINDOW_CNT = cnt_t'(FEED_WINDOW);

endpackage

// ----- src/triac_zero_cross_phase_scheduler.sv -----
// Triac phase-angle scheduler fed by zero-cross detector edges.
// Input stream: one transfer per detector edge. tuser[0] is the edge kind
// (0 falling, 1 rising), tdata[15:0] the 16-bit timer stamp at the edge.
// A falling edge only records its stamp and yields no output transfer.
// A rising edge yields one output transfer: smoke fan firing delay, the
// shared exchange/feed compare value and three channel enables.
// Config channel: cfg_index_i selects a register, cfg_data_i holds the value;
// always ready, unused indexes are dropped. Write only while no edge is in
// flight.
// A rising edge is first caught in the input register, then one pass of
// logic writes its result into the output register. The block takes one
// edge per cycle while the receiver does not stall; the timing state
// updates in the single pass so consecutive edges see each other's result.
// When the receiver stalls, the result waits in the output register and one
// more edge is held in the input register; s_axis_tready drops after that.
// Falling edges still pass through while a result waits.
// Reset clears the stamp history and midpoints, sets the last good delay to
// 4500, smoke power to 60 and starts the feed duty cycle in its on phase.
module triac_zero_cross_phase_scheduler
  import tzc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [STAMP_W-1:0]     s_axis_tdata,   // [15:0] stamp
  input  logic                   s_axis_tuser,   // [0] op
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [13:0] fire_delay, [29:14] phase_compare, [30] smoke_fire,
  // [31] exchange_fire, [32] feed_fire, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t cfg;

  logic               in_valid_q;
  edge_kind_e         in_op_q;
  logic [STAMP_W-1:0] in_stamp_q;

  logic               out_valid_q;
  logic [OUT_FIELD_W-1:0] out_data_q;

  logic out_free, step, rise_step, in_take;
  logic [DELAY_W-1:0] fire_delay;
  logic [STAMP_W-1:0] phase_compare;
  logic               feed_fire;

  tzc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_free  = !out_valid_q || m_axis_tready;
  assign step      = in_valid_q && (in_op_q == EDGE_FALL || out_free);
  assign rise_step = step && in_op_q == EDGE_RISE;
  assign s_axis_tready = !in_valid_q || step;
  assign in_take   = s_axis_tvalid && s_axis_tready;

  tzc_phase_calc u_phase (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .op_i            (in_op_q),
    .stamp_i         (in_stamp_q),
    .smoke_power_i   (cfg.smoke_power),
    .fire_delay_o    (fire_delay),
    .phase_compare_o (phase_compare)
  );

  tzc_feed_ctrl u_feed (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (rise_step),
    .cfg_i       (cfg),
    .feed_fire_o (feed_fire)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (rise_step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q    <= edge_kind_e'(s_axis_tuser);
      in_stamp_q <= s_axis_tdata;
    end
    if (rise_step) begin
      out_data_q <= {feed_fire, cfg.exchange_enable, cfg.smoke_enable,
                     phase_compare, fire_delay};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data_q);

  a_rise_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rise_step |=> m_axis_tvalid)
    else $error("rising edge produced no result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !rise_step)
    else $error("result overwritten while stalled");

endmodule

// ----- src/tzc_cfg_regs.sv -----
module tzc_cfg_regs
  import tzc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_SMOKE_POWER:     cfg_d.smoke_power     = cfg_data_i[POWER_W-1:0];
        REG_SMOKE_ENABLE:    cfg_d.smoke_enable    = cfg_data_i[0];
        REG_EXCHANGE_ENABLE: cfg_d.exchange_enable = cfg_data_i[0];
        REG_FEED_MANUAL:     cfg_d.feed_manual     = cfg_data_i[0];
        REG_FEED_ALWAYS:     cfg_d.feed_always     = cfg_data_i[0];
        REG_FEED_AUTO:       cfg_d.feed_auto       = cfg_data_i[0];
        REG_FEED_SHARE:      cfg_d.feed_share      = cfg_data_i[DUTY_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{POWER_DEFAULT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/tzc_phase_calc.sv -----
module tzc_phase_calc
  import tzc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  edge_kind_e         op_i,
  input  logic [STAMP_W-1:0] stamp_i,
  input  logic [POWER_W-1:0] smoke_power_i,
  output logic [DELAY_W-1:0] fire_delay_o,
  output logic [STAMP_W-1:0] phase_compare_o
);

  logic [STAMP_W-1:0] prev_fall_q, prev_rise_q, cur_fall_q;
  logic [MID_W-1:0]   mid_prev_q, mid_cur_q, mid_prev_d, mid_cur_d;
  logic [DELAY_W-1:0] good_delay_q;

  logic [MID_W-1:0]    sum13, sum46;
  logic [MID_W:0]      sum13_w, sum46_w;
  logic [MID_W:0]      diff;
  logic [PERIOD_W-1:0] period, quarter, t7_raw, t7;
  logic [POWER_W-1:0]  power;
  logic [PERIOD_W:0]   delay_sum;
  logic                delay_bad;

  always_comb begin
    sum13   = MID_W'(prev_fall_q) + MID_W'(prev_rise_q);
    sum46   = MID_W'(cur_fall_q) + MID_W'(stamp_i);
    sum13_w = (MID_W+1)'(sum13) + (MID_W+1)'(WRAP);
    sum46_w = (MID_W+1)'(sum46) + (MID_W+1)'(WRAP);
    mid_prev_d = mid_prev_q;
    mid_cur_d  = mid_cur_q;
    priority if (prev_fall_q < prev_rise_q && prev_rise_q < cur_fall_q &&
                 cur_fall_q < stamp_i) begin
      mid_prev_d = sum13 >> 1;
      mid_cur_d  = sum46 >> 1;
    end else if (prev_rise_q < prev_fall_q) begin
      mid_prev_d = sum13_w[MID_W:1];
      mid_cur_d  = (sum46 >> 1) + MID_W'(WRAP);
    end else if (cur_fall_q < prev_rise_q) begin
      mid_prev_d = sum13 >> 1;
      mid_cur_d  = (sum46 >> 1) + MID_W'(WRAP);
    end else if (stamp_i < cur_fall_q) begin
      mid_prev_d = sum13 >> 1;
      mid_cur_d  = sum46_w[MID_W:1];
    end else begin
      // equal stamps: midpoints hold
      mid_prev_d = mid_prev_q;
      mid_cur_d  = mid_cur_q;
    end
  end

  // modulo 2^32 period and phase time
  always_comb begin
    diff    = {1'b0, mid_cur_d} - {1'b0, mid_prev_d};
    period  = {{(PERIOD_W-MID_W-1){diff[MID_W]}}, diff};
    quarter = period >> 2;
    t7_raw  = PERIOD_W'(mid_cur_d) + quarter - PERIOD_W'(stamp_i);
    if (MID_W'(stamp_i) < mid_cur_d) begin
      t7_raw = t7_raw - PERIOD_W'(WRAP);
    end
    t7 = (t7_raw == '0) ? T7_ZERO_SUB : t7_raw;

    power     = (smoke_power_i == '0) ? POWER_DEFAULT : smoke_power_i;
    delay_sum = (PERIOD_W+1)'(t7) + (PERIOD_W+1)'(power);
    delay_bad = delay_sum > (PERIOD_W+1)'(MAX_DELAY);

    fire_delay_o    = delay_bad ? good_delay_q : delay_sum[DELAY_W-1:0];
    phase_compare_o = STAMP_W'(t7 + quarter);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_fall_q  <= '0;
      prev_rise_q  <= '0;
      cur_fall_q   <= '0;
      mid_prev_q   <= '0;
      mid_cur_q    <= '0;
      good_delay_q <= GOOD_DELAY_RST;
    end else if (step_i) begin
      unique case (op_i)
        EDGE_FALL: cur_fall_q <= stamp_i;
        EDGE_RISE: begin
          prev_fall_q  <= cur_fall_q;
          prev_rise_q  <= stamp_i;
          mid_prev_q   <= mid_prev_d;
          mid_cur_q    <= mid_cur_d;
          good_delay_q <= fire_delay_o;
        end
        default: cur_fall_q <= cur_fall_q;
      endcase
    end
  end

  a_good_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    good_delay_q <= MAX_DELAY)
    else $error("good delay out of range");

  a_fall_keeps_mids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && op_i == EDGE_FALL |=> $stable(mid_cur_q) && $stable(good_delay_q))
    else $error("falling edge changed timing state");

endmodule

// ----- src/tzc_feed_duty.sv -----
module tzc_feed_ctrl
  import tzc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  cfg_t cfg_i,
  output logic feed_fire_o
);

  cnt_t              count_q, count_inc, on_cnt, off_cnt;
  logic              running_q;
  logic [DUTY_W-1:0] duty_sat;
  logic              auto_mode;

  always_comb begin
    duty_sat  = (cfg_i.feed_share > DUTY_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : cfg_i.feed_share;
    on_cnt    = (duty_sat == '0) ? HALF_CNT : ON_TBL[duty_sat];
    off_cnt   = (duty_sat == '0) ? HALF_CNT : WINDOW_CNT - on_cnt;
    auto_mode = cfg_i.feed_auto && !cfg_i.feed_manual;
    count_inc = count_q + cnt_t'(1);
    feed_fire_o = ((cfg_i.feed_manual || cfg_i.feed_always) && !cfg_i.feed_auto) ||
                  (auto_mode && running_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      running_q <= 1'b1;
    end else if (step_i && auto_mode) begin
      if (running_q) begin
        if (count_inc >= on_cnt) begin
          count_q   <= '0;
          running_q <= 1'b0;
        end else begin
          count_q <= count_inc;
        end
      end else begin
        if (count_inc >= off_cnt) begin
          count_q   <= '0;
          running_q <= 1'b1;
        end else begin
          count_q <= count_inc;
        end
      end
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < WINDOW_CNT)
    else $error("feed count beyond window");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(count_q) && $stable(running_q))
    else $error("feed state moved without a transfer");

endmodule

// ----- dv/tb_triac_zero_cross_phase_scheduler.sv -----
module tb_triac_zero_cross_phase_scheduler;
  import tzc_pkg::*;

  localparam int DIR_ROWS       = 24;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 100;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic [STAMP_W-1:0] compare;
    logic               smoke;
    logic               exch;
    logic               feed;
  } firing_t;

  typedef struct packed {
    edge_kind_e         kind;
    logic [STAMP_W-1:0] stamp;
    logic               typed;
    firing_t            want;
  } edge_row_t;

  // Directed rows: reset state, wrap branches, equal stamps, zero t7,
  // delay above range and delay carry.
  localparam edge_row_t EDGE_TBL [DIR_ROWS] = '{
    '{EDGE_RISE, 16'd0,     1'b1, '{14'd280, 16'd220, 1'b0, 1'b0, 1'b0}},
    '{EDGE_RISE, 16'hffff,  1'b1, '{14'd280, 16'd1,   1'b0, 1'b0, 1'b0}},
    '{EDGE_FALL, 16'd100,   1'b0, '0},
    '{EDGE_RISE, 16'd30,    1'b0, '0},
    '{EDGE_FALL, 16'd200,   1'b0, '0},
    '{EDGE_RISE, 16'd300,   1'b0, '0},
    '{EDGE_FALL, 16'd400,   1'b0, '0},
    '{EDGE_RISE, 16'd500,   1'b0, '0},
    '{EDGE_FALL, 16'd60000, 1'b0, '0},
    '{EDGE_RISE, 16'd10,    1'b0, '0},
    '{EDGE_FALL, 16'd20,    1'b0, '0},
    '{EDGE_RISE, 16'd40,    1'b0, '0},
    '{EDGE_FALL, 16'd40,    1'b0, '0},
    '{EDGE_RISE, 16'd40,    1'b0, '0},
    '{EDGE_FALL, 16'd1000,  1'b0, '0},
    '{EDGE_RISE, 16'd1200,  1'b0, '0},
    '{EDGE_FALL, 16'd11000, 1'b0, '0},
    '{EDGE_RISE, 16'd11200, 1'b0, '0},
    '{EDGE_FALL, 16'd61000, 1'b0, '0},
    '{EDGE_RISE, 16'd61200, 1'b0, '0},
    '{EDGE_FALL, 16'd5000,  1'b0, '0},
    '{EDGE_RISE, 16'd5200,  1'b0, '0},
    '{EDGE_FALL, 16'hffff,  1'b0, '0},
    '{EDGE_RISE, 16'd0,     1'b0, '0}
  };

  // power, smoke, exchange, manual, full, auto, duty
  localparam cfg_t PHASE_CFG [NUM_PHASES] = '{
    '{14'd0,     1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 7'd0},
    '{14'd8999,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 7'd50},
    '{14'd1,     1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 7'd1},
    '{14'h3fff,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd100},
    '{14'd500,   1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 7'd99},
    '{14'd3000,  1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 7'd127},
    '{14'd0,     1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 7'd64},
    '{14'd0,     1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 7'd0}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [STAMP_W-1:0]     s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  triac_zero_cross_phase_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scheduler state as seen from outside
  cfg_t        sched_cfg     = '{POWER_DEFAULT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0};
  logic [31:0] hist_fall     = '0;
  logic [31:0] hist_rise     = '0;
  logic [31:0] open_fall     = '0;
  logic [31:0] mid_old       = '0;
  logic [31:0] mid_new       = '0;
  logic [31:0] last_good     = 32'(GOOD_DELAY_RST);
  logic [31:0] feed_cnt      = '0;
  logic        feed_on       = 1'b1;

  firing_t firing_q [$];
  int      errors = 0;
  int      idle_cycles = 0;
  bit      src_steady;
  bit      sink_steady;

  function automatic bit schedule_edge(input edge_kind_e kind,
                                       input logic [STAMP_W-1:0] stamp,
                                       output firing_t res);
    logic [31:0] t1, t3, t4, t6, period, quarter, t7, power, delay;
    logic [31:0] duty, on_cnt, off_cnt;
    logic        feed;
    res = '0;
    if (kind == EDGE_FALL) begin
      open_fall = 32'(stamp);
      return 1'b0;
    end
    t1 = hist_fall;
    t3 = hist_rise;
    t4 = open_fall;
    t6 = 32'(stamp);
    if (t1 < t3 && t3 < t4 && t4 < t6) begin
      mid_old = (t1 + t3) >> 1;
      mid_new = (t4 + t6) >> 1;
    end else if (t3 < t1) begin
      mid_old = (t1 + t3 + 32'(WRAP)) >> 1;
      mid_new = ((t4 + t6) >> 1) + 32'(WRAP);
    end else if (t4 < t3) begin
      mid_old = (t1 + t3) >> 1;
      mid_new = ((t4 + t6) >> 1) + 32'(WRAP);
    end else if (t6 < t4) begin
      mid_old = (t1 + t3) >> 1;
      mid_new = (t4 + t6 + 32'(WRAP)) >> 1;
    end
    period  = mid_new - mid_old;
    quarter = period >> 2;
    t7      = mid_new + quarter - t6;
    if (t6 < mid_new) t7 = t7 - 32'(WRAP);
    hist_fall = open_fall;
    hist_rise = t6;
    if (t7 == 0) t7 = T7_ZERO_SUB;

    power = (sched_cfg.smoke_power == 0) ? 32'(POWER_DEFAULT) : 32'(sched_cfg.smoke_power);
    delay = t7 + power;
    if (delay > 32'(MAX_DELAY) || delay < t7) begin
      delay = last_good;
    end else begin
      last_good = delay;
    end

    duty = (sched_cfg.feed_share > DUTY_MAX) ? DUTY_MAX : 32'(sched_cfg.feed_share);
    if (duty == 0) begin
      on_cnt  = FEED_WINDOW / 2;
      off_cnt = FEED_WINDOW / 2;
    end else begin
      on_cnt  = (duty * FEED_WINDOW) / 100;
      off_cnt = FEED_WINDOW - on_cnt;
    end

    feed = (sched_cfg.feed_manual || sched_cfg.feed_always) && !sched_cfg.feed_auto;
    if (sched_cfg.feed_auto && !sched_cfg.feed_manual) begin
      feed_cnt = feed_cnt + 1;
      if (feed_on) begin
        feed = 1'b1;
        if (feed_cnt >= on_cnt) begin
          feed_cnt = 0;
          feed_on  = 1'b0;
        end
      end else if (feed_cnt >= off_cnt) begin
        feed_cnt = 0;
        feed_on  = 1'b1;
      end
    end

    res.delay   = delay[DELAY_W-1:0];
    res.compare = 16'(t7 + quarter);
    res.smoke   = sched_cfg.smoke_enable;
    res.exch    = sched_cfg.exchange_enable;
    res.feed    = feed;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_edge(input edge_kind_e kind, input logic [STAMP_W-1:0] stamp,
                           input logic typed, input firing_t want);
    int      gap;
    firing_t res;
    if ($urandom_range(0, 31) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = stamp;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    if (schedule_edge(kind, stamp, res)) firing_q.push_back(typed ? want : res);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      REG_SMOKE_POWER:     sched_cfg.smoke_power     = val[POWER_W-1:0];
      REG_SMOKE_ENABLE:    sched_cfg.smoke_enable    = val[0];
      REG_EXCHANGE_ENABLE: sched_cfg.exchange_enable = val[0];
      REG_FEED_MANUAL:     sched_cfg.feed_manual     = val[0];
      REG_FEED_ALWAYS:     sched_cfg.feed_always     = val[0];
      REG_FEED_AUTO:       sched_cfg.feed_auto       = val[0];
      REG_FEED_SHARE:      sched_cfg.feed_share      = val[DUTY_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (firing_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    cfg_t               pc;
    logic [STAMP_W-1:0] ts;
    logic [STAMP_W-1:0] hp;
    logic [STAMP_W-1:0] pw;
    logic [STAMP_W-1:0] last_stamp;
    int                 items;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = EDGE_FALL;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    ts            = '0;
    last_stamp    = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_edge(EDGE_TBL[i].kind, EDGE_TBL[i].stamp, EDGE_TBL[i].typed, EDGE_TBL[i].want);
    end
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      pc = PHASE_CFG[p];
      if (p >= 6) pc.smoke_power = POWER_W'($urandom_range(0, int'(MAX_DELAY)));
      write_reg(REG_SMOKE_POWER,     CFG_DATA_W'(pc.smoke_power));
      write_reg(REG_SMOKE_ENABLE,    CFG_DATA_W'(pc.smoke_enable));
      write_reg(REG_EXCHANGE_ENABLE, CFG_DATA_W'(pc.exchange_enable));
      write_reg(REG_FEED_MANUAL,     CFG_DATA_W'(pc.feed_manual));
      write_reg(REG_FEED_ALWAYS,     CFG_DATA_W'(pc.feed_always));
      write_reg(REG_FEED_AUTO,       CFG_DATA_W'(pc.feed_auto));
      write_reg(REG_FEED_SHARE,      CFG_DATA_W'(pc.feed_share));
      write_reg(REG_UNUSED,          CFG_DATA_W'($urandom));
      @(negedge clk_i);

      hp    = STAMP_W'($urandom_range(2000, 40000));
      pw    = STAMP_W'($urandom_range(50, 2000));
      items = 0;
      while (items < PHASE_ITEMS) begin
        if ($urandom_range(0, 6) == 0) begin
          // noise: stray edges, repeated stamps, random stamps
          case ($urandom_range(0, 2))
            0: begin
              last_stamp = STAMP_W'($urandom);
              send_edge(edge_kind_e'($urandom_range(0, 1)), last_stamp, 1'b0, '0);
            end
            1: send_edge(EDGE_RISE, last_stamp, 1'b0, '0);
            default: begin
              last_stamp = STAMP_W'($urandom);
              send_edge(EDGE_FALL, last_stamp, 1'b0, '0);
            end
          endcase
          items++;
        end else begin
          ts = ts + hp + STAMP_W'($urandom_range(0, 64));
          last_stamp = ts + pw + STAMP_W'($urandom_range(0, 16));
          send_edge(EDGE_FALL, ts, 1'b0, '0);
          send_edge(EDGE_RISE, last_stamp, 1'b0, '0);
          items += 2;
        end
      end
      drain_results();
    end

    if (firing_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results expected, none received", $time, firing_q.size());
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    firing_t                want;
    logic [OUT_TDATA_W-1:0] d;
    int                     stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_steady = !sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      d = m_axis_tdata;
      if (firing_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, d);
      end else begin
        want = firing_q.pop_front();
        check_field("fire_delay",    32'(want.delay),   32'(d[13:0]));
        check_field("phase_compare", 32'(want.compare), 32'(d[29:14]));
        check_field("smoke_fire",    32'(want.smoke),   32'(d[30]));
        check_field("exchange_fire", 32'(want.exch),    32'(d[31]));
        check_field("feed_fire",     32'(want.feed),    32'(d[32]));
        check_field("tdata padding", 32'(0),            32'(d[OUT_TDATA_W-1:OUT_FIELD_W]));
      end
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
